// ===== hw/rtl/morphing_wavetable_oscillator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef MORPHING_WAVETABLE_OSCILLATOR_DEFINES_SVH
`define MORPHING_WAVETABLE_OSCILLATOR_DEFINES_SVH

// Same-cycle implication, also checked while reset is high.
`define MWO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MWO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mwo_pkg.sv =====
`timescale 1ns / 1ps
package mwo_pkg;

  // Default bank geometry
  localparam int DEF_TABLE_LENGTH = 2048;
  localparam int DEF_NUM_TABLES   = 8;

  // Port widths
  localparam int OP_W       = 2;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 16;
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 19;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Field placement in s_tdata
  localparam int SEL_LSB = 0;
  localparam int SEL_W   = 3;
  localparam int IDX_LSB = 3;
  localparam int IDX_W   = 11;
  localparam int VAL_LSB = 14;
  localparam int VAL_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP     = 1'b0,
    CFG_TABLE_POSITION = 1'b1
  } cfg_idx_t;

  // Width of one queued command: kind, two tables, two entries, phase fraction, morph fraction
  function automatic int cmd_width(input int tw, input int iw);
    return 1 + 2 * tw + 2 * iw + 32;
  endfunction

endpackage

// ===== hw/rtl/morphing_wavetable_oscillator.sv =====
`timescale 1ns / 1ps
// Morphing wavetable oscillator. Words go into the bank through write items (op 1);
// each tick item (op 0) yields one Q1.15 sample, interpolated along the phase and then
// across the two tables picked by table_position, and advances the phase by phase_step;
// op 2 clears the phase; op 3 is dropped. Only ticks produce an output word. The front
// takes one item per cycle while its two-entry command queue has room; the back handles
// a write in its idle state; for a tick it takes the command, makes four reads through
// the single memory port, takes three steps on the shared multiplier and one sum, and
// then loads the output register once it is free. It handles one command at a time. A
// finished sample waits in the output register while the next command proceeds. Table
// entries read before being written give undefined samples; there is no clearing pass
// after reset. Write configuration only when no tick is outstanding.
module morphing_wavetable_oscillator #(
  parameter int TABLE_LENGTH = mwo_pkg::DEF_TABLE_LENGTH,
  parameter int NUM_TABLES   = mwo_pkg::DEF_NUM_TABLES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // op
  input  logic [mwo_pkg::OP_W-1:0]       s_tuser,
  // table_select [2:0], entry_index [13:3], entry_value [29:14], zero [31:30]
  input  logic [mwo_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // sample [15:0]
  output logic [mwo_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                           cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mwo_pkg::*;

  localparam int TW = $clog2(NUM_TABLES);
  localparam int IW = $clog2(TABLE_LENGTH);
  localparam int CW = cmd_width(TW, IW);
  localparam int DEPTH = NUM_TABLES * TABLE_LENGTH;
  localparam int AW = $clog2(DEPTH);

  logic          q_push;
  logic [CW-1:0] q_in;
  logic          q_pop;
  logic [CW-1:0] q_head;
  logic          q_valid;
  logic          q_full;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata;
  logic [15:0]   ram_rdata;

  mwo_front #(
    .TABLE_LENGTH(TABLE_LENGTH),
    .NUM_TABLES  (NUM_TABLES),
    .CW          (CW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  mwo_queue #(
    .WIDTH(CW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_valid),
    .full     (q_full)
  );

  mwo_back #(
    .TABLE_LENGTH(TABLE_LENGTH),
    .NUM_TABLES  (NUM_TABLES),
    .CW          (CW),
    .AW          (AW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_head),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mwo_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_bank (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

// ===== hw/rtl/mwo_ram.sv =====
`timescale 1ns / 1ps
module mwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/mwo_queue.sv =====
`timescale 1ns / 1ps
module mwo_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head      = slot[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/mwo_front.sv =====
`timescale 1ns / 1ps
module mwo_front #(
  parameter int TABLE_LENGTH = mwo_pkg::DEF_TABLE_LENGTH,
  parameter int NUM_TABLES   = mwo_pkg::DEF_NUM_TABLES,
  parameter int CW           = 72
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mwo_pkg::OP_W-1:0]        s_tuser,
  input  logic [mwo_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            cfg_we,
  input  logic [mwo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwo_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            q_push,
  output logic [CW-1:0]                   q_data,
  input  logic                            q_full
);
  import mwo_pkg::*;

  localparam int TW = $clog2(NUM_TABLES);
  localparam int IW = $clog2(TABLE_LENGTH);
  localparam int PW = 32 + IW;
  localparam logic [31:0] POS_MAX = 32'((NUM_TABLES - 1) * 65536);

  typedef struct packed {
    logic          is_write;
    logic [TW-1:0] t0;
    logic [TW-1:0] t1;
    logic [IW-1:0] i0;
    logic [IW-1:0] i1;
    logic [15:0]   frac;
    logic [15:0]   g;
  } cmd_t;

  logic [31:0]      phase;
  logic [31:0]      phase_step;
  logic [POS_W-1:0] table_position;

  logic             accept;
  logic [SEL_W-1:0] sel;
  logic [IDX_W-1:0] idx;
  logic [VAL_W-1:0] val;
  logic             wr_ok;
  logic [PW-1:0]    p;
  logic [IW-1:0]    i0;
  logic [IW-1:0]    i1;
  logic [POS_W-1:0] pos;
  logic [TW-1:0]    t0;
  logic [TW-1:0]    t1;
  cmd_t             cmd;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign sel      = s_tdata[SEL_LSB +: SEL_W];
  assign idx      = s_tdata[IDX_LSB +: IDX_W];
  assign val      = s_tdata[VAL_LSB +: VAL_W];
  assign wr_ok    = (32'(sel) < 32'(NUM_TABLES)) && (32'(idx) < 32'(TABLE_LENGTH));

  // Split the phase into entry index and fraction
  assign p  = PW'(phase) * PW'(TABLE_LENGTH);
  assign i0 = p[PW-1:32];
  assign i1 = ((32'(i0) + 32'd1) == 32'(TABLE_LENGTH)) ? '0 : i0 + IW'(1);

  // Clamp the morph position and pick the table pair
  assign pos = (32'(table_position) > POS_MAX) ? POS_W'(POS_MAX) : table_position;
  assign t0  = TW'(pos >> 16);
  assign t1  = (32'(t0) == 32'(NUM_TABLES - 1)) ? t0 : t0 + TW'(1);

  // Build the queued command
  always_comb begin
    cmd.is_write = (s_tuser == OP_WRITE);
    cmd.t0       = t0;
    cmd.t1       = t1;
    cmd.i0       = i0;
    cmd.i1       = i1;
    cmd.frac     = p[31:16];
    cmd.g        = pos[15:0];
    q_push       = 1'b0;
    case (s_tuser)
      OP_TICK: begin
        q_push = accept;
      end
      OP_WRITE: begin
        q_push   = accept && wr_ok;
        cmd.t0   = TW'(sel);
        cmd.i0   = IW'(idx);
        cmd.frac = val;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  assign q_data = cmd;

  // Hold configuration and advance or clear the phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      phase_step     <= '0;
      table_position <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PHASE_STEP:     phase_step     <= cfg_data;
          CFG_TABLE_POSITION: table_position <= cfg_data[POS_W-1:0];
          default:            ;
        endcase
      end
      if (accept) begin
        case (s_tuser)
          OP_TICK:    phase <= phase + phase_step;
          OP_RESTART: phase <= '0;
          default:    ;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/mwo_back.sv =====
`timescale 1ns / 1ps
module mwo_back #(
  parameter int TABLE_LENGTH = mwo_pkg::DEF_TABLE_LENGTH,
  parameter int NUM_TABLES   = mwo_pkg::DEF_NUM_TABLES,
  parameter int CW           = 72,
  parameter int AW           = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [CW-1:0]                 q_data,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_addr,
  output logic [15:0]                   ram_wdata,
  input  logic [15:0]                   ram_rdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [mwo_pkg::M_TDATA_W-1:0] m_tdata
);
  import mwo_pkg::*;

  localparam int TW = $clog2(NUM_TABLES);
  localparam int IW = $clog2(TABLE_LENGTH);

  typedef struct packed {
    logic          is_write;
    logic [TW-1:0] t0;
    logic [TW-1:0] t1;
    logic [IW-1:0] i0;
    logic [IW-1:0] i1;
    logic [15:0]   frac;
    logic [15:0]   g;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL0,
    ST_MUL1,
    ST_SUM1,
    ST_MUL2,
    ST_OUT
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [TW-1:0] t, input logic [IW-1:0] i);
    return AW'(AW'(t) * AW'(TABLE_LENGTH) + AW'(i));
  endfunction

  state_t             state;
  cmd_t               head;
  cmd_t               cmd;
  logic [1:0]         k;
  logic               cap_en;
  logic [1:0]         cap_idx;
  logic signed [15:0] w [4];
  logic signed [31:0] v0;
  logic signed [31:0] v1;
  logic signed [49:0] prod;
  logic signed [16:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [49:0] mul_p;
  logic [47:0]        acc;
  logic               out_load;

  assign head = q_data;

  // Drive the memory port and the queue pop
  always_comb begin
    q_pop     = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = head.frac;
    ram_addr  = addr_of(cmd.t0, cmd.i0);
    case (state)
      ST_IDLE: begin
        q_pop    = q_valid;
        ram_we   = q_valid && head.is_write;
        ram_addr = addr_of(head.t0, head.i0);
      end
      ST_READ: begin
        case (k)
          2'd0:    ram_addr = addr_of(cmd.t0, cmd.i0);
          2'd1:    ram_addr = addr_of(cmd.t0, cmd.i1);
          2'd2:    ram_addr = addr_of(cmd.t1, cmd.i0);
          default: ram_addr = addr_of(cmd.t1, cmd.i1);
        endcase
      end
      default: ;
    endcase
  end

  // Shared multiplier: phase fraction times word difference, then morph fraction
  always_comb begin
    mul_a = {1'b0, cmd.frac};
    mul_b = {{17{w[1][15]}}, w[1]} - {{17{w[0][15]}}, w[0]};
    case (state)
      ST_MUL1: begin
        mul_b = {{17{w[3][15]}}, w[3]} - {{17{w[2][15]}}, w[2]};
      end
      ST_MUL2: begin
        mul_a = {1'b0, cmd.g};
        mul_b = {v1[31], v1} - {v0[31], v0};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // Final sum; the upper 16 bits are the floored sample
  assign acc = {v0, 16'h0000} + prod[47:0];

  // Load the output register once the previous sample has left
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Sequence one command
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= 2'd0;
      cap_en   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      cap_en  <= (state == ST_READ);
      cap_idx <= k;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid && !head.is_write) begin
            cmd   <= head;
            k     <= 2'd0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          prod  <= mul_p;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          v0    <= {w[0], 16'h0000} + prod[31:0];
          prod  <= mul_p;
          state <= ST_SUM1;
        end
        ST_SUM1: begin
          v1    <= {w[2], 16'h0000} + prod[31:0];
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          prod  <= mul_p;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tdata <= acc[47:32];
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture each read word in the cycle after its address
  always_ff @(posedge clk) begin
    if (cap_en) begin
      w[cap_idx] <= ram_rdata;
    end
  end

endmodule

// ===== hw/rtl/mwo_checker.sv =====
`timescale 1ns / 1ps
`include "morphing_wavetable_oscillator_defines.svh"
module mwo_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mwo_pkg::M_TDATA_W-1:0] m_tdata
);

  // A stalled sample holds
  `MWO_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled sample changed")

  // Reset empties the queue and the output register
  `MWO_ASSERT_NOW(a_reset_clear, $past(rst), !m_tvalid && s_tready, "reset left block busy")

  // No sample can appear after reset before a tick has passed the queue and the back
  `MWO_ASSERT_NOW(a_no_early_out, $past(rst, 2), !m_tvalid, "sample too soon after reset")

  // The queue only fills through an accepted word
  `MWO_ASSERT_NOW(a_ready_drop, $fell(s_tready), $past(s_tvalid && s_tready), "ready fell without input")

endmodule

bind morphing_wavetable_oscillator mwo_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
